// File: design/abas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC block averager and scaler - shared definitions
// Widths, fixed-point constants, register and channel codes, payload types
// and the sequencer state type used across the block.
// ----------------------------------------------------------------------------
package abas_pkg;

  // Default block length in ADC sequences (legal range 1 to 16)
  localparam int unsigned SAMPLES_PER_BLOCK = 10;

  localparam int CHANNELS = 7;
  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 16;
  localparam int GAIN_W   = 24;
  localparam int PROD_W   = 40;
  localparam int Q_W      = 32;
  localparam int VOLT_W   = 18;
  localparam int HSUM_W   = 34;
  localparam int TOT_W    = 35;

  // Reciprocal divider: every dividend stays below 2^30, the reciprocal
  // fits 32 bits and the shift reaches at most 34
  localparam int DIVIDEND_W    = 30;
  localparam int RECIP_W       = 32;
  localparam int RECIP_SHIFT_W = 6;

  // APB register map
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_A = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_B = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_C = 2'd2;
  localparam logic [GAIN_W-1:0]    GAIN_RESET = 24'd65536;

  // Channel positions in the scaling pass
  localparam logic [CH_W-1:0] CH_PRESS_A = 3'd0;
  localparam logic [CH_W-1:0] CH_PRESS_B = 3'd1;
  localparam logic [CH_W-1:0] CH_PRESS_C = 3'd2;
  localparam logic [CH_W-1:0] CH_ANGLE   = 3'd3;
  localparam logic [CH_W-1:0] CH_VOLT_E  = 3'd4;
  localparam logic [CH_W-1:0] CH_VOLT_F  = 3'd5;
  localparam logic [CH_W-1:0] CH_VOLT_G  = 3'd6;

  // Scaling constants
  // angle: 66.5 - avg*3/4096*100 in Q16.16, 4800 = 3*100*65536/4096
  localparam logic [GAIN_W-1:0]    ANGLE_COEF      = 24'd4800;
  // volts: avg*3/4096 in Q16.16, 48 = 3*65536/4096
  localparam logic [GAIN_W-1:0]    VOLT_COEF       = 24'd48;
  localparam logic signed [Q_W-1:0] ANGLE_OFFSET    = 32'sd4358144;
  localparam logic signed [Q_W-1:0] PRESSURE_OFFSET = 32'sd327680;
  // pressure: S*15*g/(16384*N); 15/16384 folds 3/4096 and 1.25 with the Q shift
  localparam int PRESS_SHIFT = 14;
  localparam int PRESS_HALF  = 8192;

  // Five-point moving average; the bias is a multiple of five that keeps the
  // dividend positive and below 2^30, plus two for rounding. The quotient
  // comes out lifted by 2^27.
  localparam int AVG_POINTS     = 5;
  localparam int AVG_LIFT_SHIFT = 27;
  localparam logic [DIVIDEND_W-1:0] AVG_BIAS =
    (DIVIDEND_W'(AVG_POINTS) << AVG_LIFT_SHIFT) + DIVIDEND_W'(AVG_POINTS / 2);
  localparam logic signed [Q_W-1:0] AVG_LIFT = 32'sd134217728;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_ch1;
    logic [SAMPLE_W-1:0] sample_ch2;
    logic [SAMPLE_W-1:0] sample_ch3;
    logic [SAMPLE_W-1:0] sample_ch4;
    logic [SAMPLE_W-1:0] sample_ch5;
    logic [SAMPLE_W-1:0] sample_ch6;
    logic [SAMPLE_W-1:0] sample_ch7;
  } in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] pressure_a;
    logic signed [Q_W-1:0] pressure_b;
    logic signed [Q_W-1:0] pressure_c;
    logic signed [Q_W-1:0] angle_smoothed;
    logic [VOLT_W-1:0]     voltage_e;
    logic [VOLT_W-1:0]     voltage_f;
    logic [VOLT_W-1:0]     voltage_g;
  } result_t;

  typedef struct packed {
    logic                     start;
    logic [DIVIDEND_W-1:0]    dividend;
    logic [RECIP_W-1:0]       recip;
    logic [RECIP_SHIFT_W-1:0] shift;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_POST,
    ST_AVG_SUM,
    ST_AVG_START,
    ST_AVG_DIV,
    ST_AVG_POST,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: design/abas_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Valid/ready stream channel
// Carries one payload per transaction, taken when valid and ready are high.
// ----------------------------------------------------------------------------
interface abas_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/abas_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reciprocal divider
// Divides by a constant through its scaled reciprocal: latch, multiply, then
// shift. Start sets a busy flag, and done pulses as the product is registered;
// the quotient holds until the next start.
// ----------------------------------------------------------------------------
module abas_divider (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire abas_pkg::div_req_t req,
  output abas_pkg::div_rsp_t      rsp
);

  localparam int DW = abas_pkg::DIVIDEND_W;
  localparam int RW = abas_pkg::RECIP_W;
  localparam int SW = abas_pkg::RECIP_SHIFT_W;
  localparam int PW = DW + RW;

  logic [DW-1:0] dvd;
  logic [RW-1:0] recip;
  logic [SW-1:0] shift;
  logic [PW-1:0] prod;
  logic          busy;
  logic          done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= req.start;
      done <= busy && !req.start;
      if (req.start) begin
        dvd   <= req.dividend;
        recip <= req.recip;
        shift <= req.shift;
      end
      if (busy && !req.start) begin
        prod <= PW'(dvd) * PW'(recip);
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = DW'(prod >> shift);

endmodule
`default_nettype wire

// File: design/adc_block_average_scaler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC block averager and scaler
// Sums seven ADC channels over a block of sequences, then scales each channel
// into pressure, smoothed angle or volts in fixed point.
// ----------------------------------------------------------------------------
// Each accepted transaction on adc is one seven-channel ADC sequence, and the
// block takes sequences back to back while idle. Every SAMPLES_PER_BLOCK-th
// sequence closes the block and starts a scaling pass, during which adc.ready
// is low: each of the seven channels goes once through a single shared 16x24
// multiplier and a shared reciprocal divider (one multiply and a shift), and
// the angle takes a second division for its five-point average. The finished
// result sits in an output register, so the next block is summed while it
// waits on result; a pass that ends while that register is still full holds
// in its done state until the waiting transaction completes.
// Pressure gains are written over APB at byte addresses 0, 4 and 8.
// ----------------------------------------------------------------------------
module adc_block_average_scaler #(
  parameter int unsigned SAMPLES_PER_BLOCK = abas_pkg::SAMPLES_PER_BLOCK
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  abas_stream_if.sink                          adc,
  abas_stream_if.source                        result,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [abas_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [abas_pkg::APB_DATA_W-1:0] pwdata,
  output logic [abas_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam int CNT_W  = $clog2(SAMPLES_PER_BLOCK + 1);
  localparam int SUM_W  = abas_pkg::SUM_W;
  localparam int GAIN_W = abas_pkg::GAIN_W;
  localparam int PROD_W = abas_pkg::PROD_W;
  localparam int WIDE_W = PROD_W + 4;
  localparam int DW     = abas_pkg::DIVIDEND_W;
  localparam int RW     = abas_pkg::RECIP_W;
  localparam int SW     = abas_pkg::RECIP_SHIFT_W;
  localparam int Q_W    = abas_pkg::Q_W;
  localparam int VOLT_W = abas_pkg::VOLT_W;
  localparam int HSUM_W = abas_pkg::HSUM_W;
  localparam int TOT_W  = abas_pkg::TOT_W;
  localparam int DATA_W = abas_pkg::APB_DATA_W;
  localparam int RIW    = abas_pkg::REG_IDX_W;

  // Round-half terms of the divisions by the block length
  localparam logic [PROD_W-1:0] HALF_N      = PROD_W'(SAMPLES_PER_BLOCK / 2);
  localparam logic [WIDE_W-1:0] PRESS_ROUND =
    WIDE_W'(abas_pkg::PRESS_HALF * SAMPLES_PER_BLOCK);
  localparam logic [CNT_W-1:0]  COUNT_LAST  = CNT_W'(SAMPLES_PER_BLOCK - 1);

  // floor(x/d) = (x * ceil(2^(30+l)/d)) >> (30+l) with 2^l >= d, exact for
  // every dividend below 2^30
  localparam int N_LOG = $clog2(SAMPLES_PER_BLOCK);
  localparam int A_LOG = $clog2(abas_pkg::AVG_POINTS);
  localparam logic [SW-1:0] SHIFT_N   = SW'(DW + N_LOG);
  localparam logic [SW-1:0] SHIFT_AVG = SW'(DW + A_LOG);
  localparam logic [RW-1:0] RECIP_N   =
    RW'(((64'd1 << (DW + N_LOG)) + 64'(SAMPLES_PER_BLOCK) - 64'd1) /
        64'(SAMPLES_PER_BLOCK));
  localparam logic [RW-1:0] RECIP_AVG =
    RW'(((64'd1 << (DW + A_LOG)) + 64'(abas_pkg::AVG_POINTS) - 64'd1) /
        64'(abas_pkg::AVG_POINTS));

  abas_pkg::state_t state;
  abas_pkg::state_t state_next;

  // Configuration
  logic [GAIN_W-1:0] gain_a;
  logic [GAIN_W-1:0] gain_b;
  logic [GAIN_W-1:0] gain_c;
  logic              cfg_write;
  logic [RIW-1:0]    reg_idx;

  // Accumulation
  logic [SUM_W-1:0]                  sums [abas_pkg::CHANNELS];
  logic [abas_pkg::SAMPLE_W-1:0]     in_samples [abas_pkg::CHANNELS];
  logic [CNT_W-1:0]                  count;
  logic                              accept;
  logic                              last_seq;

  // Scaling pass
  logic [abas_pkg::CH_W-1:0]  ch;
  logic [GAIN_W-1:0]          coef;
  logic [PROD_W-1:0]          mul_full;
  logic [PROD_W-1:0]          prod;
  logic [WIDE_W-1:0]          prod15;
  logic [WIDE_W-1:0]          press_rounded;
  logic [DW-1:0]              press_dividend;
  logic [DW-1:0]              lin_dividend;
  logic [DW-1:0]              avg_dividend;
  logic [Q_W-1:0]             quo_low;
  logic signed [Q_W-1:0]      angle;
  logic signed [Q_W-1:0]      hist [4];
  logic signed [HSUM_W-1:0]   hist_sum;
  logic signed [TOT_W-1:0]    total;
  abas_pkg::result_t          work;
  abas_pkg::result_t          out_res;
  logic                       out_valid;
  logic                       out_free;

  abas_pkg::div_req_t div_req;
  abas_pkg::div_rsp_t div_rsp;

  abas_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // --------------------------------------------------------------------------
  // APB register port: no wait states, writes land at the access phase
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = paddr[abas_pkg::APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      abas_pkg::REG_GAIN_A: prdata = DATA_W'(gain_a);
      abas_pkg::REG_GAIN_B: prdata = DATA_W'(gain_b);
      abas_pkg::REG_GAIN_C: prdata = DATA_W'(gain_c);
      default:              prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input side: unpack the sequence, flag the last one of a block
  // --------------------------------------------------------------------------
  assign in_samples[0] = adc.data.sample_ch1;
  assign in_samples[1] = adc.data.sample_ch2;
  assign in_samples[2] = adc.data.sample_ch3;
  assign in_samples[3] = adc.data.sample_ch4;
  assign in_samples[4] = adc.data.sample_ch5;
  assign in_samples[5] = adc.data.sample_ch6;
  assign in_samples[6] = adc.data.sample_ch7;

  assign accept   = adc.valid && adc.ready;
  assign last_seq = (count == COUNT_LAST);
  assign out_free = !out_valid || result.ready;

  // --------------------------------------------------------------------------
  // Shared datapath
  // --------------------------------------------------------------------------
  // Coefficient for the channel under way: pressure gain, angle or volt scale
  always_comb begin
    case (ch)
      abas_pkg::CH_PRESS_A: coef = gain_a;
      abas_pkg::CH_PRESS_B: coef = gain_b;
      abas_pkg::CH_PRESS_C: coef = gain_c;
      abas_pkg::CH_ANGLE:   coef = abas_pkg::ANGLE_COEF;
      default:              coef = abas_pkg::VOLT_COEF;
    endcase
  end

  assign mul_full = PROD_W'(sums[ch]) * PROD_W'(coef);

  // Pressure: round(S*g*15 / (16384*N)) split into a rounding shift by 16384
  // and a division by N; the nested floors give the same quotient
  assign prod15         = {prod, 4'b0000} - {4'b0000, prod};
  assign press_rounded  = prod15 + PRESS_ROUND;
  assign press_dividend = DW'(press_rounded >> abas_pkg::PRESS_SHIFT);
  // Angle and volts: round(S*coef / N)
  assign lin_dividend   = DW'(prod + HALF_N);
  // Five-point average: floor((total + 2) / 5) on a biased, positive dividend
  assign avg_dividend   = $unsigned(DW'(total)) + abas_pkg::AVG_BIAS;

  // Quotients stay far inside 32 bits, so pressure and angle never clamp
  assign quo_low = Q_W'(div_rsp.quotient);

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      abas_pkg::ST_IDLE: begin
        if (accept && last_seq) state_next = abas_pkg::ST_MUL;
      end
      abas_pkg::ST_MUL:  state_next = abas_pkg::ST_PREP;
      abas_pkg::ST_PREP: state_next = abas_pkg::ST_DIV;
      abas_pkg::ST_DIV: begin
        if (div_rsp.done) state_next = abas_pkg::ST_POST;
      end
      abas_pkg::ST_POST: begin
        if (ch == abas_pkg::CH_ANGLE) begin
          state_next = abas_pkg::ST_AVG_SUM;
        end else if (ch == abas_pkg::CH_VOLT_G) begin
          state_next = abas_pkg::ST_DONE;
        end else begin
          state_next = abas_pkg::ST_MUL;
        end
      end
      abas_pkg::ST_AVG_SUM:   state_next = abas_pkg::ST_AVG_START;
      abas_pkg::ST_AVG_START: state_next = abas_pkg::ST_AVG_DIV;
      abas_pkg::ST_AVG_DIV: begin
        if (div_rsp.done) state_next = abas_pkg::ST_AVG_POST;
      end
      abas_pkg::ST_AVG_POST: state_next = abas_pkg::ST_MUL;
      abas_pkg::ST_DONE: begin
        if (out_free) state_next = abas_pkg::ST_IDLE;
      end
      default: state_next = abas_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    adc.ready        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = lin_dividend;
    div_req.recip    = RECIP_N;
    div_req.shift    = SHIFT_N;
    case (state)
      abas_pkg::ST_IDLE: adc.ready = 1'b1;
      abas_pkg::ST_PREP: begin
        div_req.start = 1'b1;
        if (ch inside {[abas_pkg::CH_PRESS_A:abas_pkg::CH_PRESS_C]}) begin
          div_req.dividend = press_dividend;
        end
      end
      abas_pkg::ST_AVG_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = avg_dividend;
        div_req.recip    = RECIP_AVG;
        div_req.shift    = SHIFT_AVG;
      end
      default: ;
    endcase
  end

  assign result.valid = out_valid;
  assign result.data  = out_res;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= abas_pkg::ST_IDLE;
      gain_a    <= abas_pkg::GAIN_RESET;
      gain_b    <= abas_pkg::GAIN_RESET;
      gain_c    <= abas_pkg::GAIN_RESET;
      count     <= '0;
      ch        <= abas_pkg::CH_PRESS_A;
      out_valid <= 1'b0;
      hist_sum  <= '0;
      for (int i = 0; i < abas_pkg::CHANNELS; i++) sums[i] <= '0;
      for (int i = 0; i < 4; i++) hist[i] <= '0;
    end else begin
      state <= state_next;

      // Keep the low 24 bits of a gain write; drop writes past the map
      if (cfg_write) begin
        case (reg_idx)
          abas_pkg::REG_GAIN_A: gain_a <= pwdata[GAIN_W-1:0];
          abas_pkg::REG_GAIN_B: gain_b <= pwdata[GAIN_W-1:0];
          abas_pkg::REG_GAIN_C: gain_c <= pwdata[GAIN_W-1:0];
          default: ;
        endcase
      end

      // Accumulate; sixteen full-scale sequences still fit the sums
      if (accept) begin
        for (int i = 0; i < abas_pkg::CHANNELS; i++) begin
          sums[i] <= sums[i] + SUM_W'(in_samples[i]);
        end
        count <= last_seq ? '0 : count + 1'b1;
      end

      // Load a finished result, or release the output register once the
      // transaction completes
      if (state == abas_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        abas_pkg::ST_MUL: prod <= mul_full;
        abas_pkg::ST_POST: begin
          case (ch)
            abas_pkg::CH_PRESS_A:
              work.pressure_a <= $signed(quo_low) - abas_pkg::PRESSURE_OFFSET;
            abas_pkg::CH_PRESS_B:
              work.pressure_b <= $signed(quo_low) - abas_pkg::PRESSURE_OFFSET;
            abas_pkg::CH_PRESS_C:
              work.pressure_c <= $signed(quo_low) - abas_pkg::PRESSURE_OFFSET;
            abas_pkg::CH_ANGLE:
              angle <= abas_pkg::ANGLE_OFFSET - $signed(quo_low);
            abas_pkg::CH_VOLT_E: work.voltage_e <= quo_low[VOLT_W-1:0];
            abas_pkg::CH_VOLT_F: work.voltage_f <= quo_low[VOLT_W-1:0];
            default:             work.voltage_g <= quo_low[VOLT_W-1:0];
          endcase
          // Hold the channel at the angle and at the end of the pass
          if (ch != abas_pkg::CH_ANGLE && ch != abas_pkg::CH_VOLT_G) begin
            ch <= ch + 1'b1;
          end
        end
        abas_pkg::ST_AVG_SUM: total <= TOT_W'(hist_sum) + TOT_W'(angle);
        abas_pkg::ST_AVG_START: begin
          // Advance the history, oldest entry drops out of the running sum
          hist[0]  <= hist[1];
          hist[1]  <= hist[2];
          hist[2]  <= hist[3];
          hist[3]  <= angle;
          hist_sum <= HSUM_W'(total - TOT_W'(hist[0]));
        end
        abas_pkg::ST_AVG_POST: begin
          // Take the lift of the biased dividend back off the quotient
          work.angle_smoothed <= $signed(quo_low) - abas_pkg::AVG_LIFT;
          ch                  <= ch + 1'b1;
        end
        abas_pkg::ST_DONE: begin
          if (out_free) begin
            out_res   <= work;
            ch        <= abas_pkg::CH_PRESS_A;
            for (int i = 0; i < abas_pkg::CHANNELS; i++) sums[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/abas_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC block averager and scaler - port checker
// Watches the top-level channels over time and reports slips by $error.
// ----------------------------------------------------------------------------
module abas_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire abas_pkg::result_t out_data
);

  localparam logic [abas_pkg::VOLT_W-1:0] VOLT_MAX = 18'd196608;

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A fresh result only follows a scaling pass, when input was held off
  a_new_after_pass: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a scaling pass");

  // No new input item is taken in the cycle that loads a fresh result
  a_no_take_at_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !($past(in_valid) && $past(in_ready)))
    else $error("input taken while loading a result");

  // Averaged volts never exceed three volts
  a_volt_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.voltage_e <= VOLT_MAX && out_data.voltage_f <= VOLT_MAX
                  && out_data.voltage_g <= VOLT_MAX)
    else $error("voltage out of range");

endmodule

bind adc_block_average_scaler abas_checker u_abas_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (adc.valid),
  .in_ready  (adc.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.data)
);
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC block averager and scaler - self-checking testbench
// Streams seven-channel ADC sequences into the block, predicts every block
// result (pressures, smoothed angle, volts) in fixed point and compares it
// field by field, while gains are reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module testbench;
  import abas_pkg::*;

  // Block length used both by the instance and by the prediction
  localparam longint unsigned BLOCK_LEN = SAMPLES_PER_BLOCK;
  // 3/4096 volts, 1.25 pressure scale and the Q16 shift fold into 15/16384
  localparam longint unsigned PRESSURE_NUM = 15;
  localparam longint unsigned PRESSURE_DEN = (longint'(1) << PRESS_SHIFT) * BLOCK_LEN;
  // Bias that keeps the five-point dividend positive; a multiple of ten
  localparam longint AVG_LIFT = longint'(1) << 33;
  // The scaling pass plus some slack: the quiet time before a register write
  localparam int SETTLE_CYCLES = 140;
  // Address slot past the last gain register; writes there must change nothing
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int REPORT_CAP = 40;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 250;

  // --------------------------------------------------------------------------
  // Expected block results: tracks the running sums, gains and angle history,
  // queues the result each completed block must produce and checks arrivals.
  // --------------------------------------------------------------------------
  class block_result_tracker;
    logic [GAIN_W-1:0]     gain [3];
    logic [SUM_W-1:0]      sums [CHANNELS];
    int unsigned           seq_count;
    logic signed [Q_W-1:0] angle_past [4];
    result_t               awaited [$];
    int unsigned           fault_count;
    int unsigned           blocks_checked;

    function new();
      foreach (gain[i]) gain[i] = GAIN_RESET;
      foreach (sums[i]) sums[i] = '0;
      foreach (angle_past[i]) angle_past[i] = '0;
      seq_count = 0;
      fault_count = 0;
      blocks_checked = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void set_gain(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
      case (idx)
        REG_GAIN_A: gain[0] = value[GAIN_W-1:0];
        REG_GAIN_B: gain[1] = value[GAIN_W-1:0];
        REG_GAIN_C: gain[2] = value[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [Q_W-1:0] clamp_q16(input longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
      if (v < -longint'(64'h8000_0000)) return 32'sh8000_0000;
      return v[Q_W-1:0];
    endfunction

    // Block average times a coefficient, rounded half up
    function longint unsigned scaled_avg(input logic [SUM_W-1:0] sum,
                                         input longint unsigned coef);
      return (longint'(sum) * coef + BLOCK_LEN / 2) / BLOCK_LEN;
    endfunction

    function logic signed [Q_W-1:0] pressure_q16(input logic [SUM_W-1:0] sum,
                                                 input logic [GAIN_W-1:0] g);
      longint unsigned q;
      q = (longint'(sum) * PRESSURE_NUM * longint'(g) + PRESSURE_DEN / 2) / PRESSURE_DEN;
      return clamp_q16(longint'(q) - longint'(PRESSURE_OFFSET));
    endfunction

    function void take_sequence(input in_t seq);
      logic [SAMPLE_W-1:0] ch [CHANNELS];
      result_t             r;
      longint              angle;
      longint              total;
      longint unsigned     t;
      ch = '{seq.sample_ch1, seq.sample_ch2, seq.sample_ch3, seq.sample_ch4,
             seq.sample_ch5, seq.sample_ch6, seq.sample_ch7};
      foreach (sums[i]) sums[i] = sums[i] + SUM_W'(ch[i]);
      seq_count++;
      if (seq_count < BLOCK_LEN) return;

      r.pressure_a = pressure_q16(sums[0], gain[0]);
      r.pressure_b = pressure_q16(sums[1], gain[1]);
      r.pressure_c = pressure_q16(sums[2], gain[2]);

      angle = longint'(ANGLE_OFFSET) - longint'(scaled_avg(sums[3], ANGLE_COEF));
      angle = clamp_q16(angle);
      total = angle;
      foreach (angle_past[i]) total += angle_past[i];
      for (int i = 0; i < 3; i++) angle_past[i] = angle_past[i + 1];
      angle_past[3] = angle[Q_W-1:0];
      // round((total)/5) half up, done as floor((2*total+5)/10) on a lifted dividend
      t = longint'(2 * total + 5 + 10 * AVG_LIFT) / 10;
      r.angle_smoothed = clamp_q16(longint'(t) - AVG_LIFT);

      r.voltage_e = VOLT_W'(scaled_avg(sums[4], VOLT_COEF));
      r.voltage_f = VOLT_W'(scaled_avg(sums[5], VOLT_COEF));
      r.voltage_g = VOLT_W'(scaled_avg(sums[6], VOLT_COEF));
      awaited.push_back(r);

      foreach (sums[i]) sums[i] = '0;
      seq_count = 0;
    endfunction

    task report(input string what);
      fault_count++;
      if (fault_count <= REPORT_CAP) $display("ERROR: %s", what);
    endtask

    task check_field(input string name, input longint got_v, input longint want_v);
      if (got_v != want_v)
        report($sformatf("block %0d %s: got %0d, expected %0d",
                         blocks_checked, name, got_v, want_v));
    endtask

    task match_result(input result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        report("result transaction with no completed block behind it");
        return;
      end
      want = awaited.pop_front();
      if ($isunknown(got)) report($sformatf("block %0d: unknown bits in result",
                                            blocks_checked));
      check_field("pressure_a", got.pressure_a, want.pressure_a);
      check_field("pressure_b", got.pressure_b, want.pressure_b);
      check_field("pressure_c", got.pressure_c, want.pressure_c);
      check_field("angle_smoothed", got.angle_smoothed, want.angle_smoothed);
      check_field("voltage_e", got.voltage_e, want.voltage_e);
      check_field("voltage_f", got.voltage_f, want.voltage_f);
      check_field("voltage_g", got.voltage_g, want.voltage_g);
      blocks_checked++;
    endtask

    task flag_leftovers();
      if (awaited.size() != 0)
        report($sformatf("%0d block results never arrived", awaited.size()));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  // Idling switches for the two sides of the stream, set per phase
  bit tx_gaps;
  bit rx_stalls;

  block_result_tracker tracker = new();

  abas_stream_if #(.payload_t(in_t))     adc_if ();
  abas_stream_if #(.payload_t(result_t)) res_if ();

  adc_block_average_scaler #(
    .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK)
  ) uut (
    .clk(clk),
    .rst(rst),
    .adc(adc_if),
    .result(res_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Random shaping: mostly short gaps and stalls, now and then a long one
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Long stalls can outlast a scaling pass, so back-pressure reaches the adc side
  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  // Lean on the rails of the converter range, otherwise uniform
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic in_t make_sequence();
    in_t s;
    s.sample_ch1 = pick_sample();
    s.sample_ch2 = pick_sample();
    s.sample_ch3 = pick_sample();
    s.sample_ch4 = pick_sample();
    s.sample_ch5 = pick_sample();
    s.sample_ch6 = pick_sample();
    s.sample_ch7 = pick_sample();
    return s;
  endfunction

  // Gains: zero, full scale, unity or anything; junk in the unused top byte
  function automatic logic [31:0] pick_gain();
    logic [7:0] junk;
    junk = 8'($urandom);
    case ($urandom_range(0, 5))
      0: return {junk, 24'd0};
      1: return {junk, 24'hFF_FFFF};
      2: return {junk, GAIN_RESET};
      default: return {junk, 24'($urandom)};
    endcase
  endfunction

  function automatic in_t flat_sequence(input logic [SAMPLE_W-1:0] v);
    return '{v, v, v, v, v, v, v};
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // One APB write: setup cycle, then access cycle until pready. Then drop psel
  // and idle before returning, so back-to-back writes never clash in one step.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_gain(idx, value);
    @(posedge clk);
  endtask

  // Offer one sequence after the given gap and hold it until the transaction
  // completes. valid stays high across back-to-back sequences.
  task automatic send_sequence(input in_t seq, input int gap);
    if (gap > 0) begin
      adc_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    adc_if.valid <= 1'b1;
    adc_if.data  <= seq;
    do @(posedge clk); while (!adc_if.ready);
    tracker.take_sequence(seq);
  endtask

  // Drop valid and wait for every predicted result to come back
  task automatic drain();
    adc_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Quiet point for register writes: nothing outstanding, pass finished
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: check each completed transaction, then choose ready for the
  // next cycle. A stall is held for its whole length before ready returns.
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) tracker.match_result(res_if.data);
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        hold_left = rx_stalls ? pick_stall() : 0;
        res_if.ready <= (hold_left == 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int pause_at;
    in_t seq;
    adc_if.valid = 1'b0;
    adc_if.data  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // First block at power-up gains: rails, alternating bit patterns and
    // per-channel mixes. Its angle also sees the cleared history.
    send_sequence(flat_sequence(12'h000), 0);
    send_sequence(flat_sequence(12'hFFF), 0);
    send_sequence(flat_sequence(12'hAAA), 0);
    send_sequence(flat_sequence(12'h555), 0);
    send_sequence('{12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF}, 0);
    send_sequence('{12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h000}, 0);
    send_sequence('{12'h001, 12'h800, 12'h7FF, 12'hFFE, 12'h123, 12'hABC, 12'hF0F}, 0);
    repeat (3) send_sequence(make_sequence(), 0);

    // Gain extremes: full scale with junk in the top byte, zero and the smallest
    // step. A write past the last register must leave the gains alone.
    settle();
    write_reg(REG_GAIN_A, 32'hFFFF_FFFF);
    write_reg(REG_GAIN_B, 32'h0000_0000);
    write_reg(REG_GAIN_C, 32'h0000_0001);
    write_reg(REG_UNMAPPED, 32'h0012_3456);

    // Second block: every channel pinned at full scale for the largest sums
    repeat (SAMPLES_PER_BLOCK) send_sequence(flat_sequence(12'hFFF), 0);

    // Random phases, each with fresh gains and its own idling mix; the first
    // phase runs flat out on both sides
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      write_reg(REG_GAIN_A, pick_gain());
      write_reg(REG_GAIN_B, pick_gain());
      write_reg(REG_GAIN_C, pick_gain());
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNMAPPED, $urandom);
      tx_gaps   = (phase % 4) != 0 && (phase % 4) != 2;
      rx_stalls = (phase % 4) != 0 && (phase % 4) != 3;
      pause_at  = $urandom_range(20, PHASE_ITEMS - 20);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Hold the sender once per phase until the block has caught up
        if (i == pause_at) drain();
        seq = make_sequence();
        send_sequence(seq, tx_gaps ? pick_gap() : 0);
      end
    end

    // Let the last results come home, then allow one more pass of slack
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    tracker.flag_leftovers();
    if (tracker.fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
